@@ design/toy_risc_instruction_step_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the toy RISC step block
// Short forms for same-cycle and next-cycle implications on the block clock.
// ----------------------------------------------------------------------------
`ifndef TOY_RISC_INSTRUCTION_STEP_ASSERT_SVH
`define TOY_RISC_INSTRUCTION_STEP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TRS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/trs_pkg.sv @@
// ----------------------------------------------------------------------------
// trs_pkg
// Types and constants shared by the toy RISC step block and its units.
// ----------------------------------------------------------------------------
package trs_pkg;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_REGCAP,
      S_DECODE,
      S_EXEC,
      S_MEM,
      S_LDWB,
      S_RESP
   } state_type;

   typedef enum logic [2:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_AND,
      ALU_OR
   } alu_op_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clr_en;
   } mem_ctl_type;

   // Item opcodes.
   localparam logic [1:0] ITEM_WRITE = 2'd0;
   localparam logic [1:0] ITEM_EXEC  = 2'd1;
   localparam logic [1:0] ITEM_READ  = 2'd2;

   // Instruction opcodes.
   localparam logic [5:0] OP_NOP  = 6'h00;
   localparam logic [5:0] OP_ADDI = 6'h14;
   localparam logic [5:0] OP_ADD  = 6'h10;
   localparam logic [5:0] OP_SUB  = 6'h08;
   localparam logic [5:0] OP_MUL  = 6'h0C;
   localparam logic [5:0] OP_ANDI = 6'h04;
   localparam logic [5:0] OP_ORI  = 6'h0A;
   localparam logic [5:0] OP_BEQ  = 6'h02;
   localparam logic [5:0] OP_BNE  = 6'h03;
   localparam logic [5:0] OP_LW   = 6'h20;
   localparam logic [5:0] OP_SW   = 6'h28;
   localparam logic [5:0] OP_HALT = 6'h3F;

   // Result status codes.
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_HALT    = 3'd1;
   localparam logic [2:0] ST_BADOP   = 3'd2;
   localparam logic [2:0] ST_LOADB   = 3'd3;
   localparam logic [2:0] ST_STOREB  = 3'd4;
   localparam logic [2:0] ST_FETCHB  = 3'd5;
   localparam logic [2:0] ST_STOPPED = 3'd6;

   localparam logic [31:0] PC_STEP = 32'd4;

endpackage

@@ design/trs_alu.sv @@
// ----------------------------------------------------------------------------
// trs_alu
// Shared arithmetic unit: add, subtract, low-word multiply, and, or.
// ----------------------------------------------------------------------------
module trs_alu (
   input  trs_pkg::alu_op_type op,
   input  logic [31:0]         a,
   input  logic [31:0]         b,
   output logic [31:0]         y
);
   import trs_pkg::*;

   always_comb begin
      case (op)
         ALU_ADD: y = a + b;
         ALU_SUB: y = a - b;
         ALU_MUL: y = a * b;
         ALU_AND: y = a & b;
         ALU_OR:  y = a | b;
         default: y = a + b;
      endcase
   end

endmodule

@@ design/trs_regs.sv @@
// ----------------------------------------------------------------------------
// trs_regs
// 32 x 32 register file, two registered read ports, one write port.
// ----------------------------------------------------------------------------
module trs_regs (
   input  logic        clock,
   input  logic        reset,
   input  logic [4:0]  ra_addr,
   input  logic [4:0]  rb_addr,
   input  logic        wr_en,
   input  logic [4:0]  wr_addr,
   input  logic [31:0] wr_data,
   output logic [31:0] ra_data,
   output logic [31:0] rb_data
);
   import trs_pkg::*;

   logic [31:0] rf_mem [32];
   logic [31:0] valid_ff;
   logic [31:0] ra_ff;
   logic [31:0] rb_ff;

   // An entry never written since reset reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rf_mem[wr_addr] <= wr_data;
      end
      ra_ff <= valid_ff[ra_addr] ? rf_mem[ra_addr] : 32'd0;
      rb_ff <= valid_ff[rb_addr] ? rf_mem[rb_addr] : 32'd0;
   end

   assign ra_data = ra_ff;
   assign rb_data = rb_ff;

endmodule

@@ design/trs_mem.sv @@
// ----------------------------------------------------------------------------
// trs_mem
// Byte memory in four banks, so that any unaligned word is one access.
// ----------------------------------------------------------------------------
module trs_mem #(
   parameter  int MEM_BYTES = 65536,
   localparam int ROWS      = (MEM_BYTES + 3) / 4,
   localparam int ROW_W     = $clog2(ROWS),
   localparam int ADDR_W    = ROW_W + 2
) (
   input  logic                 clock,
   input  trs_pkg::mem_ctl_type ctl,
   input  logic [ADDR_W-1:0]    addr,
   input  logic [31:0]          wr_data,
   input  logic [ROW_W-1:0]     clr_row,
   output logic [31:0]          rd_word
);
   import trs_pkg::*;

   logic [7:0]       q_ff [4];
   logic [1:0]       lo_ff;
   logic [1:0]       lo;
   logic [ROW_W-1:0] base_row;
   logic [3:0][7:0]  wr_bytes;

   assign lo       = addr[1:0];
   assign base_row = addr[ADDR_W-1:2];
   assign wr_bytes = wr_data;

   // Byte k of the word sits in bank (lo + k) mod 4, one row further on
   // for the banks that come before the starting bank.
   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [7:0]       bank_mem [ROWS];
      logic [ROW_W-1:0] row;
      logic [1:0]       k;
      logic [7:0]       wbyte;

      always_comb begin
         k = 2'(b) - lo;
         if (ctl.clr_en) begin
            row   = clr_row;
            wbyte = 8'd0;
         end else begin
            row   = base_row + ROW_W'(2'(b) < lo);
            wbyte = wr_bytes[k];
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.wr_en || ctl.clr_en) begin
            bank_mem[row] <= wbyte;
         end
         if (ctl.rd_en) begin
            q_ff[b] <= bank_mem[row];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         lo_ff <= lo;
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         rd_word[8*k +: 8] = q_ff[2'(k) + lo_ff];
      end
   end

endmodule

@@ design/toy_risc_instruction_step.sv @@
// ----------------------------------------------------------------------------
// toy_risc_instruction_step
// Small 32-bit load/store processor stepped one item at a time.
// ----------------------------------------------------------------------------
// After reset the block clears its memory one four-byte row per cycle and
// takes no item meanwhile. Each item is then worked through a sequencer
// around one shared ALU, a banked byte memory and a register file, both with
// registered reads, and the block takes no new item until the result beat has
// left. From the accepting edge, a memory write or an ignored item passes
// through dispatch to the result; a register read adds a register capture
// state; an executed instruction passes through dispatch, decode and execute,
// a store adds a memory state, and a load a memory state and, when in range, a
// load write-back state. The block returns to idle after each result before
// the next item is taken.
// ----------------------------------------------------------------------------
`include "toy_risc_instruction_step_assert.svh"

module toy_risc_instruction_step #(
   parameter int MEM_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [15:0] req_address,
   input  logic [31:0] req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_program_counter,
   output logic        rsp_is_running,
   output logic [31:0] rsp_executed_word,
   output logic [31:0] rsp_read_value
);
   import trs_pkg::*;

   localparam int          ROWS   = (MEM_BYTES + 3) / 4;
   localparam int          ROW_W  = $clog2(ROWS);
   localparam int          ADDR_W = ROW_W + 2;
   localparam logic [31:0] LIMIT  = 32'(MEM_BYTES - 4);

   function automatic logic in_range(input logic [31:0] a);
      return a <= LIMIT;
   endfunction

   state_type        state_ff, state_in;
   logic [ROW_W-1:0] clr_ff, clr_in;
   logic [1:0]       item_ff, item_in;
   logic [15:0]      addr_ff, addr_in;
   logic [31:0]      data_ff, data_in;
   logic [2:0]       status_ff, status_in;
   logic [31:0]      pc_ff, pc_in;
   logic             run_ff, run_in;
   logic [31:0]      word_ff, word_in;
   logic [31:0]      rv_ff, rv_in;
   logic [31:0]      fetch_pc_ff, fetch_pc_in;
   logic [31:0]      ea_ff, ea_in;
   logic [31:0]      sw_ff, sw_in;

   mem_ctl_type mem_ctl;
   logic [31:0] mem_addr;
   logic [31:0] mem_wdata;
   logic [31:0] mem_word;

   logic [31:0] dec_word;
   logic [5:0]  dec_op;
   logic [4:0]  ra_addr;
   logic [31:0] ra_data;
   logic [31:0] rb_data;
   logic        rf_wr_en;
   logic [31:0] rf_wr_data;

   logic [5:0]  ins_op;
   logic [4:0]  ins_f1;
   logic [31:0] simm;
   logic [31:0] zimm;
   alu_op_type  alu_op;
   logic [31:0] alu_a;
   logic [31:0] alu_b;
   logic [31:0] alu_y;
   logic        take_branch;
   logic        accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   assign rsp_status          = status_ff;
   assign rsp_program_counter = pc_ff;
   assign rsp_is_running      = run_ff;
   assign rsp_executed_word   = word_ff;
   assign rsp_read_value      = rv_ff;

   // Register reads are issued while the fetched word is still on the
   // memory output, so the operands are ready in the execute cycle.
   assign dec_word = (state_ff == S_DECODE) ? mem_word : word_ff;
   assign dec_op   = dec_word[31:26];

   always_comb begin
      if (state_ff == S_DISPATCH) begin
         ra_addr = addr_ff[4:0];
      end else if (dec_op inside {OP_ADD, OP_SUB, OP_MUL}) begin
         ra_addr = dec_word[15:11];
      end else begin
         ra_addr = dec_word[25:21];
      end
   end

   assign ins_op = word_ff[31:26];
   assign ins_f1 = word_ff[25:21];
   assign simm   = {{16{word_ff[15]}}, word_ff[15:0]};
   assign zimm   = {16'd0, word_ff[15:0]};

   always_comb begin
      case (ins_op)
         OP_SUB:  alu_op = ALU_SUB;
         OP_MUL:  alu_op = ALU_MUL;
         OP_ANDI: alu_op = ALU_AND;
         OP_ORI:  alu_op = ALU_OR;
         default: alu_op = ALU_ADD;
      endcase
      case (ins_op)
         OP_BEQ, OP_BNE: alu_a = fetch_pc_ff;
         OP_LW, OP_SW:   alu_a = ra_data;
         default:        alu_a = rb_data;
      endcase
      case (ins_op)
         OP_ADD, OP_SUB, OP_MUL: alu_b = ra_data;
         OP_ANDI, OP_ORI:        alu_b = zimm;
         OP_BEQ, OP_BNE:         alu_b = {simm[29:0], 2'b00};
         default:                alu_b = simm;
      endcase
   end

   assign take_branch = ((ins_op == OP_BEQ) && (ra_data == rb_data)) ||
                        ((ins_op == OP_BNE) && (ra_data != rb_data));

   trs_alu u_alu (
      .op (alu_op),
      .a  (alu_a),
      .b  (alu_b),
      .y  (alu_y)
   );

   trs_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .ra_addr (ra_addr),
      .rb_addr (dec_word[20:16]),
      .wr_en   (rf_wr_en),
      .wr_addr (ins_f1),
      .wr_data (rf_wr_data),
      .ra_data (ra_data),
      .rb_data (rb_data)
   );

   trs_mem #(
      .MEM_BYTES (MEM_BYTES)
   ) u_mem (
      .clock   (clock),
      .ctl     (mem_ctl),
      .addr    (mem_addr[ADDR_W-1:0]),
      .wr_data (mem_wdata),
      .clr_row (clr_ff),
      .rd_word (mem_word)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == ROW_W'(ROWS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            if (item_ff == ITEM_EXEC && run_ff && in_range(pc_ff)) begin
               state_in = S_DECODE;
            end else if (item_ff == ITEM_READ) begin
               state_in = S_REGCAP;
            end else begin
               state_in = S_RESP;
            end
         end
         S_REGCAP: state_in = S_RESP;
         S_DECODE: state_in = S_EXEC;
         S_EXEC: begin
            if (ins_op inside {OP_LW, OP_SW}) state_in = S_MEM;
            else state_in = S_RESP;
         end
         S_MEM: begin
            if (ins_op == OP_LW && in_range(ea_ff)) state_in = S_LDWB;
            else state_in = S_RESP;
         end
         S_LDWB: state_in = S_RESP;
         S_RESP: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Memory and register file controls.
   always_comb begin
      mem_ctl    = '0;
      mem_addr   = pc_ff;
      mem_wdata  = data_ff;
      rf_wr_en   = 1'b0;
      rf_wr_data = alu_y;
      case (state_ff)
         S_CLEAR: mem_ctl.clr_en = 1'b1;
         S_DISPATCH: begin
            if (item_ff == ITEM_WRITE) begin
               mem_addr       = {16'd0, addr_ff};
               mem_ctl.wr_en  = in_range({16'd0, addr_ff});
            end else if (item_ff == ITEM_EXEC) begin
               mem_ctl.rd_en  = run_ff && in_range(pc_ff);
            end
         end
         S_EXEC: begin
            rf_wr_en = ins_op inside {OP_ADDI, OP_ADD, OP_SUB, OP_MUL, OP_ANDI, OP_ORI};
         end
         S_MEM: begin
            mem_addr  = ea_ff;
            mem_wdata = sw_ff;
            if (in_range(ea_ff)) begin
               mem_ctl.rd_en = (ins_op == OP_LW);
               mem_ctl.wr_en = (ins_op == OP_SW);
            end
         end
         S_LDWB: begin
            rf_wr_en   = 1'b1;
            rf_wr_data = mem_word;
         end
         default: begin
            mem_ctl = '0;
         end
      endcase
   end

   // Datapath registers.
   always_comb begin
      clr_in      = clr_ff;
      item_in     = item_ff;
      addr_in     = addr_ff;
      data_in     = data_ff;
      status_in   = status_ff;
      pc_in       = pc_ff;
      run_in      = run_ff;
      word_in     = word_ff;
      rv_in       = rv_ff;
      fetch_pc_in = fetch_pc_ff;
      ea_in       = ea_ff;
      sw_in       = sw_ff;
      case (state_ff)
         S_CLEAR: clr_in = clr_ff + ROW_W'(1);
         S_IDLE: begin
            if (accept) begin
               item_in   = req_opcode;
               addr_in   = req_address;
               data_in   = req_data;
               status_in = ST_OK;
               word_in   = 32'd0;
               rv_in     = 32'd0;
            end
         end
         S_DISPATCH: begin
            if (item_ff == ITEM_WRITE) begin
               if (!in_range({16'd0, addr_ff})) status_in = ST_STOREB;
            end else if (item_ff == ITEM_EXEC) begin
               if (!run_ff) begin
                  status_in = ST_STOPPED;
               end else if (!in_range(pc_ff)) begin
                  run_in    = 1'b0;
                  status_in = ST_FETCHB;
               end
            end
         end
         S_REGCAP: begin
            rv_in = (addr_ff[15:5] == 11'd0) ? ra_data : 32'd0;
         end
         S_DECODE: begin
            word_in     = mem_word;
            fetch_pc_in = pc_ff;
            pc_in       = pc_ff + PC_STEP;
         end
         S_EXEC: begin
            case (ins_op)
               OP_NOP, OP_ADDI, OP_ADD, OP_SUB, OP_MUL, OP_ANDI, OP_ORI: begin
                  status_in = ST_OK;
               end
               OP_BEQ, OP_BNE: begin
                  if (take_branch) pc_in = alu_y;
               end
               OP_LW, OP_SW: begin
                  ea_in = alu_y;
                  sw_in = ra_data;
               end
               OP_HALT: begin
                  run_in    = 1'b0;
                  status_in = ST_HALT;
               end
               default: begin
                  run_in    = 1'b0;
                  status_in = ST_BADOP;
               end
            endcase
         end
         S_MEM: begin
            if (!in_range(ea_ff)) begin
               run_in    = 1'b0;
               status_in = (ins_op == OP_LW) ? ST_LOADB : ST_STOREB;
            end
         end
         default: begin
            clr_in = clr_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         pc_ff    <= 32'd0;
         run_ff   <= 1'b1;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         pc_ff    <= pc_in;
         run_ff   <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      addr_ff     <= addr_in;
      data_ff     <= data_in;
      status_ff   <= status_in;
      word_ff     <= word_in;
      rv_ff       <= rv_in;
      fetch_pc_ff <= fetch_pc_in;
      ea_ff       <= ea_in;
      sw_ff       <= sw_in;
   end

   `TRS_ASSERT_SAME(a_halt_stops, clock, reset, rsp_valid && rsp_status == ST_HALT, !rsp_is_running, "HALT result still running")
   `TRS_ASSERT_SAME(a_fetchb_clean, clock, reset, rsp_valid && rsp_status == ST_FETCHB, !rsp_is_running && rsp_executed_word == 32'd0, "fetch bounds result inconsistent")
   `TRS_ASSERT_NEXT(a_no_early_rsp, clock, reset, accept, !rsp_valid, "result beat right after accept")
   `TRS_ASSERT_SAME(a_no_rf_in_clear, clock, reset, state_ff == S_CLEAR, !rf_wr_en && !mem_ctl.rd_en, "access during memory clear")

endmodule
